// ===== sv/swpp_pkg.sv =====
// Package for the sliding window packet pacer: sizes, codes, result and
// configuration types. No dependencies.
`timescale 1ns / 1ps

package swpp_pkg;

  // Storage sizes.
  localparam int Q_DEPTH = 16;
  localparam int W_DEPTH = 64;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int W_CW    = $clog2(W_DEPTH + 1);

  // Field widths.
  localparam int KIND_W = 2;
  localparam int TIME_W = 32;
  localparam int SIZE_W = 16;
  localparam int TAG_W  = 16;
  localparam int RATE_W = 20;
  localparam int OVS_W  = 16;
  localparam int WMS_W  = 16;
  localparam int QB_W   = 20;

  // Window byte total, rate plus overshoot plus one, threshold and compare widths.
  localparam int WB_W   = SIZE_W + W_CW;
  localparam int RO_W   = RATE_W + 1;
  localparam int THR_W  = RO_W + WMS_W;
  localparam int LHS_W  = WB_W + 1 + 3;
  localparam int CMP_W  = (THR_W > LHS_W) ? THR_W : LHS_W;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_OVERSHOOT  = 2'd0;
  localparam logic [1:0] REG_WINDOW_MS  = 2'd1;
  localparam logic [1:0] REG_START_RATE = 2'd2;

  localparam logic [OVS_W-1:0]  OVS_RESET   = OVS_W'(20);
  localparam logic [WMS_W-1:0]  WMS_RESET   = WMS_W'(500);
  localparam logic [RATE_W-1:0] START_RESET = RATE_W'(150);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Result status codes.
  localparam logic STAT_SENT = 1'b0;
  localparam logic STAT_DROP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MUL,
    ST_EV_RD,
    ST_EV_CHK,
    ST_REL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              status;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [QB_W-1:0]   buffered;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [OVS_W-1:0]  overshoot;
    logic [WMS_W-1:0]  window_ms;
    logic [RATE_W-1:0] start_rate;
    logic              rate_load;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [W_AW-1:0]   addr;
    logic [TIME_W-1:0] stamp;
    logic [SIZE_W-1:0] size;
  } win_wr_t;

endpackage

// ===== sv/swpp_if.sv =====
// Valid/ready channel interfaces for the pacer's input items and result items.
// Depends on swpp_pkg.
`timescale 1ns / 1ps

interface swpp_in_if
  import swpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] now_ms;
  logic [SIZE_W-1:0] packet_size;
  logic [TAG_W-1:0]  packet_tag;
  logic [RATE_W-1:0] rate_kbps;

  modport source (output valid, kind, now_ms, packet_size, packet_tag, rate_kbps,
                  input ready);
  modport sink   (input valid, kind, now_ms, packet_size, packet_tag, rate_kbps,
                  output ready);
endinterface

interface swpp_out_if
  import swpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic [TAG_W-1:0]  out_tag;
  logic [SIZE_W-1:0] out_size;
  logic [QB_W-1:0]   buffered_bytes;
  logic              last;

  modport source (output valid, status, out_tag, out_size, buffered_bytes, last,
                  input ready);
  modport sink   (input valid, status, out_tag, out_size, buffered_bytes, last,
                  output ready);
endinterface

// ===== sv/sliding_window_packet_pacer.sv =====
// Top level of the sliding window packet pacer: sequencer, packet queue and
// rate test. Depends on swpp_pkg, swpp_if, swpp_cfg and swpp_win_mem.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  in_item   in         valid/ready             kind, now_ms, packet_size, packet_tag, rate_kbps
//  out_item  out        valid/ready             status, out_tag, out_size, buffered_bytes, last
//  cfg_*     in         APB, pready always high overshoot, window_ms, start_rate (0x0/0x4/0x8)
//
// An item passes through an apply step and, when packets wait, the rate threshold
// multiply, a memory read and an age compare per window record examined for
// eviction, one more read when the walk finds the window empty, one release
// step per released packet and the final release test.
// One item is processed at a time; in_item.ready is high only between items.
// Results leave through a one-entry output register; a stalled sink holds the
// sequencer at its next result. Reset is synchronous and active low; the
// queue and window are empty after reset and need no clearing pass.

module sliding_window_packet_pacer
  import swpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  swpp_in_if.sink           in_item,
  swpp_out_if.source        out_item,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers.
  cfg_t cfg;

  swpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Sequencer and item registers.
  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  // Packet queue: payload arrays plus head and fill count.
  logic [SIZE_W-1:0] p_size_r [Q_DEPTH];
  logic [TAG_W-1:0]  p_tag_r  [Q_DEPTH];
  logic [Q_AW-1:0]   p_head_r, p_head_nxt;
  logic [Q_CW-1:0]   p_cnt_r, p_cnt_nxt;
  logic              p_wr_en;
  logic [Q_AW-1:0]   p_tail;
  logic [Q_CW:0]     p_tail_sum;

  // Send window bookkeeping.
  logic [W_AW-1:0]   w_head_r, w_head_nxt;
  logic [W_CW-1:0]   w_cnt_r, w_cnt_nxt;
  logic [WB_W-1:0]   w_bytes_r, w_bytes_nxt;
  logic [W_AW-1:0]   w_tail;
  logic [W_CW:0]     w_tail_sum;
  win_wr_t           win_wr;
  logic [TIME_W-1:0] rd_stamp;
  logic [SIZE_W-1:0] rd_size;

  logic [QB_W-1:0]   q_bytes_r, q_bytes_nxt;
  logic [RATE_W-1:0] net_rate_r, net_rate_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;

  // One result waits in held_r until the sequencer knows whether another
  // follows, so that last can be set on the final one.
  logic              held_v_r, held_v_nxt;
  res_t              held_r, held_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              out_free;

  // Shared arithmetic terms.
  logic [SIZE_W-1:0] head_size;
  logic [TAG_W-1:0]  head_tag;
  logic [TIME_W-1:0] age;
  logic [WMS_W-1:0]  dur;
  logic [RO_W-1:0]   ro_sum;
  logic [CMP_W-1:0]  lhs;
  logic              may_send;

  swpp_win_mem u_win_mem (
    .clk      (clk),
    .wr       (win_wr),
    .rd_addr  (w_head_r),
    .rd_stamp (rd_stamp),
    .rd_size  (rd_size)
  );

  assign in_item.ready           = (state_r == ST_IDLE);
  assign out_item.valid          = out_v_r;
  assign out_item.status         = out_r.status;
  assign out_item.out_tag        = out_r.tag;
  assign out_item.out_size       = out_r.size;
  assign out_item.buffered_bytes = out_r.buffered;
  assign out_item.last           = out_r.last;

  assign out_free = !out_v_r || out_item.ready;

  // Queue and window write positions wrap at the storage depth.
  assign p_tail_sum = (Q_CW+1)'(p_head_r) + (Q_CW+1)'(p_cnt_r);
  assign p_tail     = (p_tail_sum >= (Q_CW+1)'(Q_DEPTH)) ?
                      Q_AW'(p_tail_sum - (Q_CW+1)'(Q_DEPTH)) : Q_AW'(p_tail_sum);
  assign w_tail_sum = (W_CW+1)'(w_head_r) + (W_CW+1)'(w_cnt_r);
  assign w_tail     = (w_tail_sum >= (W_CW+1)'(W_DEPTH)) ?
                      W_AW'(w_tail_sum - (W_CW+1)'(W_DEPTH)) : W_AW'(w_tail_sum);

  assign head_size = p_size_r[p_head_r];
  assign head_tag  = p_tag_r[p_head_r];
  assign age       = now_r - rd_stamp;

  // A window length of zero is taken as one millisecond in the rate test.
  assign dur    = (cfg.window_ms == '0) ? WMS_W'(1) : cfg.window_ms;
  assign ro_sum = RO_W'(net_rate_r) + RO_W'(cfg.overshoot) + RO_W'(1);

  // floor(x*8/dur) <= r is the same as x*8 < (r+1)*dur, with thr_r holding
  // the right-hand side.
  assign lhs = (CMP_W'(w_bytes_r) + CMP_W'(head_size)) << 3;

  always_comb begin
    if (w_cnt_r == '0) begin
      may_send = 1'b1;
    end else if (w_cnt_r >= W_CW'(W_DEPTH)) begin
      may_send = 1'b0;
    end else begin
      may_send = lhs < CMP_W'(thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      p_head_r   <= '0;
      p_cnt_r    <= '0;
      w_head_r   <= '0;
      w_cnt_r    <= '0;
      w_bytes_r  <= '0;
      q_bytes_r  <= '0;
      net_rate_r <= START_RESET;
      held_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p_head_r   <= p_head_nxt;
      p_cnt_r    <= p_cnt_nxt;
      w_head_r   <= w_head_nxt;
      w_cnt_r    <= w_cnt_nxt;
      w_bytes_r  <= w_bytes_nxt;
      q_bytes_r  <= q_bytes_nxt;
      net_rate_r <= net_rate_nxt;
      held_v_r   <= held_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    now_r  <= now_nxt;
    size_r <= size_nxt;
    tag_r  <= tag_nxt;
    rate_r <= rate_nxt;
    thr_r  <= thr_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
    if (p_wr_en) begin
      p_size_r[p_tail] <= size_r;
      p_tag_r[p_tail]  <= tag_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    now_nxt      = now_r;
    size_nxt     = size_r;
    tag_nxt      = tag_r;
    rate_nxt     = rate_r;
    p_head_nxt   = p_head_r;
    p_cnt_nxt    = p_cnt_r;
    w_head_nxt   = w_head_r;
    w_cnt_nxt    = w_cnt_r;
    w_bytes_nxt  = w_bytes_r;
    q_bytes_nxt  = q_bytes_r;
    net_rate_nxt = net_rate_r;
    thr_nxt      = thr_r;
    held_v_nxt   = held_v_r;
    held_nxt     = held_r;
    out_v_nxt    = out_v_r && !out_item.ready;
    out_nxt      = out_r;
    p_wr_en      = 1'b0;
    win_wr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          kind_nxt = in_item.kind;
          now_nxt  = in_item.now_ms;
          size_nxt = in_item.packet_size;
          tag_nxt  = in_item.packet_tag;
          rate_nxt = in_item.rate_kbps;
          // An unknown kind has no effect at all.
          state_nxt = (in_item.kind == KIND_NONE) ? ST_IDLE : ST_APPLY;
        end
      end

      ST_APPLY: begin
        case (kind_r)
          KIND_ENQ: begin
            if (p_cnt_r >= Q_CW'(Q_DEPTH)) begin
              // Queue full: the refused packet comes back as a drop result.
              held_v_nxt        = 1'b1;
              held_nxt.status   = STAT_DROP;
              held_nxt.tag      = tag_r;
              held_nxt.size     = size_r;
              held_nxt.buffered = q_bytes_r;
              held_nxt.last     = 1'b0;
            end else begin
              p_wr_en     = 1'b1;
              p_cnt_nxt   = p_cnt_r + Q_CW'(1);
              q_bytes_nxt = q_bytes_r + QB_W'(size_r);
            end
          end
          KIND_RATE: net_rate_nxt = rate_r;
          default: ;
        endcase
        // Nothing is evicted or released while the queue stays empty.
        state_nxt = (p_cnt_nxt == '0) ? ST_FIN : ST_MUL;
      end

      ST_MUL: begin
        thr_nxt   = THR_W'(ro_sum) * THR_W'(dur);
        state_nxt = ST_EV_RD;
      end

      ST_EV_RD: begin
        // The memory reads the window head this cycle.
        state_nxt = (w_cnt_r == '0) ? ST_REL : ST_EV_CHK;
      end

      ST_EV_CHK: begin
        // A send time ahead of now wraps to a large age and is evicted.
        if (age > TIME_W'(cfg.window_ms)) begin
          w_bytes_nxt = w_bytes_r - WB_W'(rd_size);
          w_head_nxt  = (w_head_r == W_AW'(W_DEPTH - 1)) ? '0 : w_head_r + W_AW'(1);
          w_cnt_nxt   = w_cnt_r - W_CW'(1);
          state_nxt   = ST_EV_RD;
        end else begin
          state_nxt = ST_REL;
        end
      end

      ST_REL: begin
        if (p_cnt_r == '0 || !may_send) begin
          state_nxt = ST_FIN;
        end else if (!held_v_r || out_free) begin
          if (held_v_r) begin
            out_v_nxt     = 1'b1;
            out_nxt       = held_r;
            out_nxt.last  = 1'b0;
          end
          held_v_nxt        = 1'b1;
          held_nxt.status   = STAT_SENT;
          held_nxt.tag      = head_tag;
          held_nxt.size     = head_size;
          held_nxt.buffered = q_bytes_r - QB_W'(head_size);
          held_nxt.last     = 1'b0;
          win_wr.en         = 1'b1;
          win_wr.addr       = w_tail;
          win_wr.stamp      = now_r;
          win_wr.size       = head_size;
          w_cnt_nxt         = w_cnt_r + W_CW'(1);
          w_bytes_nxt       = w_bytes_r + WB_W'(head_size);
          q_bytes_nxt       = q_bytes_r - QB_W'(head_size);
          p_head_nxt        = (p_head_r == Q_AW'(Q_DEPTH - 1)) ? '0 : p_head_r + Q_AW'(1);
          p_cnt_nxt         = p_cnt_r - Q_CW'(1);
        end
      end

      ST_FIN: begin
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = held_r;
          out_nxt.last = 1'b1;
          held_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Writing start_rate also reloads the network rate; the user must write it only
    // while the block is idle, as the block itself does not enforce this.
    if (cfg.rate_load) begin
      net_rate_nxt = cfg.start_rate;
    end
  end

`ifndef SYNTHESIS
  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    w_cnt_r <= W_CW'(W_DEPTH))
    else $error("window record count above its depth");

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    p_cnt_r <= Q_CW'(Q_DEPTH))
    else $error("queue count above its depth");

  a_wbytes_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (w_cnt_r == '0) |-> (w_bytes_r == '0))
    else $error("empty window holds bytes");

  a_qbytes_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (p_cnt_r == '0) |-> (q_bytes_r == '0))
    else $error("empty queue holds bytes");

  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_v_r)
    else $error("result left behind between items");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && held_v_r && out_free) |=> (out_v_r && out_r.last))
    else $error("final result not marked last");
`endif

endmodule

// ===== sv/swpp_cfg.sv =====
// APB-style configuration registers of the pacer.
// Depends on swpp_pkg.
`timescale 1ns / 1ps

module swpp_cfg
  import swpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic [OVS_W-1:0]  ovs_r;
  logic [WMS_W-1:0]  wms_r;
  logic [RATE_W-1:0] start_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovs_r   <= OVS_RESET;
      wms_r   <= WMS_RESET;
      start_r <= START_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OVERSHOOT:  ovs_r   <= pwdata[OVS_W-1:0];
        REG_WINDOW_MS:  wms_r   <= pwdata[WMS_W-1:0];
        REG_START_RATE: start_r <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OVERSHOOT:  prdata = CFG_DW'(ovs_r);
      REG_WINDOW_MS:  prdata = CFG_DW'(wms_r);
      REG_START_RATE: prdata = CFG_DW'(start_r);
      default:        prdata = '0;
    endcase
  end

  // The network rate is reloaded in the same cycle that start_rate is written.
  assign cfg.overshoot  = ovs_r;
  assign cfg.window_ms  = wms_r;
  assign cfg.start_rate = pwdata[RATE_W-1:0];
  assign cfg.rate_load  = wr_en && (reg_idx == REG_START_RATE);

endmodule

// ===== sv/swpp_win_mem.sv =====
// Send window record memory: send time and size per entry, one write port and
// one registered read port. Depends on swpp_pkg.
`timescale 1ns / 1ps

module swpp_win_mem
  import swpp_pkg::*;
(
  input  logic              clk,
  input  win_wr_t           wr,
  input  logic [W_AW-1:0]   rd_addr,
  output logic [TIME_W-1:0] rd_stamp,
  output logic [SIZE_W-1:0] rd_size
);

  logic [TIME_W-1:0] stamp_mem [W_DEPTH];
  logic [SIZE_W-1:0] size_mem  [W_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      stamp_mem[wr.addr] <= wr.stamp;
      size_mem[wr.addr]  <= wr.size;
    end
  end

  always_ff @(posedge clk) begin
    rd_stamp <= stamp_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
  end

endmodule

// ===== tb/swpp_checker.sv =====
// Result checker for the sliding window packet pacer: tracks queue, window and
// rate state from the observed items and compares every result item in order.
// Depends on swpp_pkg and swpp_if.
`timescale 1ns / 1ps

module swpp_checker
  import swpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  swpp_in_if                in_mon,
  swpp_out_if               out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                owed
);

  logic [OVS_W-1:0]  ovs_kbps;
  logic [WMS_W-1:0]  win_len;
  logic [RATE_W-1:0] net_kbps;

  logic [SIZE_W-1:0] q_size [Q_DEPTH];
  logic [TAG_W-1:0]  q_tag  [Q_DEPTH];
  logic [Q_AW-1:0]   q_head;
  logic [Q_CW-1:0]   q_cnt;
  logic [QB_W-1:0]   q_bytes;

  logic [TIME_W-1:0] w_time [W_DEPTH];
  logic [SIZE_W-1:0] w_size [W_DEPTH];
  logic [W_AW-1:0]   w_head;
  logic [W_CW-1:0]   w_cnt;
  logic [WB_W-1:0]   w_bytes;

  res_t due_results[$];
  int   errs = 0;

  // Rate test for the packet at the queue head.
  function automatic bit admits(logic [SIZE_W-1:0] sz);
    logic [63:0] dur;
    logic [63:0] lhs;
    logic [63:0] rhs;
    if (w_cnt == 0) return 1'b1;
    if (w_cnt >= W_DEPTH) return 1'b0;
    dur = (win_len == 0) ? 64'd1 : 64'(win_len);
    lhs = ((64'(w_bytes) + 64'(sz)) * 64'd8) / dur;
    rhs = 64'(net_kbps) + 64'(ovs_kbps);
    return lhs <= rhs;
  endfunction

  task automatic push_result(logic status, logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] sz);
    res_t r;
    r.status   = status;
    r.tag      = tag;
    r.size     = sz;
    r.buffered = q_bytes;
    r.last     = 1'b0;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic pace_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                           logic [SIZE_W-1:0] sz, logic [TAG_W-1:0] tag,
                           logic [RATE_W-1:0] rate);
    int                n;
    logic [Q_AW-1:0]   qslot;
    logic [W_AW-1:0]   wslot;
    logic [TIME_W-1:0] age;
    logic [SIZE_W-1:0] hsz;
    n = 0;
    if (kind == KIND_NONE) return;
    if (kind == KIND_ENQ) begin
      if (q_cnt >= Q_DEPTH) begin
        push_result(STAT_DROP, tag, sz);
        n++;
      end else begin
        qslot = Q_AW'(q_head + q_cnt);
        q_size[qslot] = sz;
        q_tag[qslot]  = tag;
        q_cnt++;
        q_bytes += QB_W'(sz);
      end
    end else if (kind == KIND_RATE) begin
      net_kbps = rate;
    end
    if (q_cnt != 0) begin
      // Old window records leave first; a send time ahead of now looks very old.
      while (w_cnt != 0) begin
        age = now - w_time[w_head];
        if (age <= TIME_W'(win_len)) break;
        w_bytes -= WB_W'(w_size[w_head]);
        w_head++;
        w_cnt--;
      end
      while (q_cnt != 0 && admits(q_size[q_head])) begin
        hsz   = q_size[q_head];
        wslot = W_AW'(w_head + w_cnt);
        w_time[wslot] = now;
        w_size[wslot] = hsz;
        w_cnt++;
        w_bytes += WB_W'(hsz);
        q_bytes -= QB_W'(hsz);
        push_result(STAT_SENT, q_tag[q_head], hsz);
        q_head++;
        q_cnt--;
        n++;
      end
    end
    if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      ovs_kbps = OVS_RESET;
      win_len  = WMS_RESET;
      net_kbps = START_RESET;
      q_head   = '0;
      q_cnt    = '0;
      q_bytes  = '0;
      w_head   = '0;
      w_cnt    = '0;
      w_bytes  = '0;
      due_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none, actual status %0d",
                    " tag %0h size %0h buffered %0h last %0d"},
                   $time, out_mon.status, out_mon.out_tag, out_mon.out_size,
                   out_mon.buffered_bytes, out_mon.last);
          errs++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_mon.status));
          check_field("out_tag", 32'(exp_r.tag), 32'(out_mon.out_tag));
          check_field("out_size", 32'(exp_r.size), 32'(out_mon.out_size));
          check_field("buffered_bytes", 32'(exp_r.buffered), 32'(out_mon.buffered_bytes));
          check_field("last", 32'(exp_r.last), 32'(out_mon.last));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_OVERSHOOT:  ovs_kbps = OVS_W'(cfg_pwdata);
          REG_WINDOW_MS:  win_len  = WMS_W'(cfg_pwdata);
          REG_START_RATE: net_kbps = RATE_W'(cfg_pwdata);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        pace_item(in_mon.kind, in_mon.now_ms, in_mon.packet_size, in_mon.packet_tag,
                  in_mon.rate_kbps);
    end
    mismatches <= errs;
    owed       <= due_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the pacer testbench: clock, reset, configuration writes and item
// stimulus with random idling on both sides. Depends on swpp_pkg, swpp_if,
// sliding_window_packet_pacer and swpp_checker.
`timescale 1ns / 1ps

module testbench;
  import swpp_pkg::*;

  // Cycles to let pass after the last expected result before touching the
  // registers; covers a full window eviction walk plus a queue of releases.
  localparam int SETTLE_CYCLES = 200;
  // Length of the long output stall that backs the block up.
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 370;
  localparam int DRAIN_LIMIT   = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatches;
  int                owed;

  swpp_in_if  in_ch ();
  swpp_out_if out_ch ();

  sliding_window_packet_pacer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_ch),
    .out_item    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  swpp_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .owed        (owed)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus state shared by the tasks below.
  logic [TIME_W-1:0] now_ms;
  logic [WMS_W-1:0]  cur_wms;
  bit                send_idle;
  bit                recv_idle;
  bit                hold_req;
  int                sent_items;

  // Result side: before every result item it may hold ready low for a random
  // gap, or for a long stretch when the stimulus asks for one. Ready then stays
  // high until an item is taken.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) gap = HOLD_CYCLES;
      else gap = recv_idle ? int'($urandom_range(0, 3)) : 0;
      hold_req = 1'b0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offers one item stamped with the current time and waits until it is
  // taken. Valid stays high afterwards so back-to-back items need no gap.
  task automatic offer(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] sz,
                       logic [TAG_W-1:0] tag, logic [RATE_W-1:0] rate);
    int gap;
    gap = send_idle ? int'($urandom_range(0, 3)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.kind        <= kind;
    in_ch.now_ms      <= now_ms;
    in_ch.packet_size <= sz;
    in_ch.packet_tag  <= tag;
    in_ch.rate_kbps   <= rate;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (kind != KIND_NONE) sent_items++;
  endtask

  // Stops offering and waits for every expected result, then lets the block
  // finish any work that produces no result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writing the start rate also reloads the network rate.
  task automatic configure(logic [OVS_W-1:0] ovs, logic [WMS_W-1:0] wms,
                           logic [RATE_W-1:0] rate);
    settle();
    write_reg(REG_OVERSHOOT, CFG_DW'(ovs));
    write_reg(REG_WINDOW_MS, CFG_DW'(wms));
    write_reg(REG_START_RATE, CFG_DW'(rate));
    cur_wms = wms;
  endtask

  task automatic random_setup();
    logic [OVS_W-1:0]  ovs;
    logic [WMS_W-1:0]  wms;
    logic [RATE_W-1:0] rate;
    int                r;
    r = $urandom_range(0, 9);
    ovs = (r < 3) ? OVS_W'($urandom) : OVS_W'($urandom_range(0, 200));
    r = $urandom_range(0, 9);
    if (r < 8) wms = WMS_W'($urandom_range(1, 2000));
    else if (r == 8) wms = WMS_W'($urandom);
    else wms = '1;
    r = $urandom_range(0, 9);
    if (r < 7) rate = RATE_W'($urandom_range(0, 3000));
    else if (r < 9) rate = RATE_W'($urandom_range(0, 1000000));
    else rate = RATE_W'($urandom);
    configure(ovs, wms, rate);
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  // Time mostly moves forward in small steps; sometimes it jumps past the
  // window, steps backward, or lands anywhere in the 32-bit range.
  task automatic step_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) now_ms += $urandom_range(0, 20);
    else if (r < 85) now_ms += $urandom_range(0, 2 * cur_wms + 2);
    else if (r < 90) now_ms -= $urandom_range(0, 1000);
    else if (r < 95) now_ms = $urandom;
  endtask

  // Mixed enqueue, tick and rate update items with a few unknown kinds.
  task automatic random_traffic(int n);
    int                r;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] sz;
    logic [RATE_W-1:0] rate;
    repeat (n) begin
      step_time();
      r = $urandom_range(0, 99);
      if (r < 55) kind = KIND_ENQ;
      else if (r < 75) kind = KIND_TICK;
      else if (r < 93) kind = KIND_RATE;
      else kind = KIND_NONE;
      r = $urandom_range(0, 9);
      if (r < 8) sz = SIZE_W'($urandom_range(0, 1500));
      else if (r == 8) sz = SIZE_W'($urandom);
      else if ($urandom_range(0, 1) == 1) sz = '1;
      else sz = '0;
      r = $urandom_range(0, 9);
      if (r < 6) rate = RATE_W'($urandom_range(0, 2000));
      else if (r < 9) rate = RATE_W'($urandom_range(0, 1000000));
      else rate = RATE_W'($urandom);
      offer(kind, sz, TAG_W'($urandom), rate);
      // Now and then the sender waits until every result is out.
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  // Fills the window record to its depth with small packets at one instant,
  // then the queue, then drops one. A final enqueue past the window length
  // drops again, empties the window and releases the whole queue.
  task automatic fill_window();
    offer(KIND_RATE, SIZE_W'($urandom), TAG_W'($urandom), '1);
    repeat (W_DEPTH + Q_DEPTH + 1)
      offer(KIND_ENQ, SIZE_W'($urandom_range(0, 200)), TAG_W'($urandom), RATE_W'($urandom));
    now_ms += cur_wms + 1;
    offer(KIND_ENQ, SIZE_W'($urandom_range(0, 200)), TAG_W'($urandom), RATE_W'($urandom));
  endtask

  initial begin
    int wait_cnt;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_TICK;
    in_ch.now_ms      <= '0;
    in_ch.packet_size <= '0;
    in_ch.packet_tag  <= '0;
    in_ch.rate_kbps   <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    sent_items = 0;
    hold_req   = 1'b0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    cur_wms    = WMS_RESET;
    now_ms     = 32'd1000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset configuration.
    offer(KIND_TICK, '0, '0, '0);                  // empty queue: no result
    offer(KIND_NONE, '1, '1, '1);                  // unknown kind is ignored
    offer(KIND_ENQ, 16'h0000, 16'h0000, '0);       // empty window always admits
    offer(KIND_ENQ, 16'hFFFF, 16'hFFFF, '0);       // far over the rate, waits
    now_ms = 32'd1500;
    offer(KIND_TICK, '0, '0, '0);                  // age equals the window: kept
    now_ms = 32'd1501;
    offer(KIND_TICK, '0, '0, '0);                  // evicted, the big packet goes
    offer(KIND_RATE, '0, '0, 20'hFFFFF);           // rate update with nothing queued
    offer(KIND_ENQ, 16'd1500, 16'h0001, '0);       // fits under the high rate
    offer(KIND_RATE, '0, '0, 20'd0);
    offer(KIND_ENQ, 16'd800, 16'h0002, '0);        // held at rate zero
    offer(KIND_ENQ, 16'd1, 16'h0003, '0);
    now_ms = 32'd600;
    offer(KIND_TICK, '0, '0, '0);                  // send times ahead of now are old
    offer(KIND_RATE, '0, '0, 20'd150);
    now_ms = 32'hFFFF_FFF0;
    offer(KIND_ENQ, 16'd5000, 16'h8000, '0);
    offer(KIND_ENQ, 16'd5000, 16'h7FFF, '0);
    offer(KIND_ENQ, 16'd2000, 16'h5555, '0);       // over the limit, waits
    now_ms = 32'h0000_01F0;
    offer(KIND_TICK, '0, '0, '0);                  // age measured across the wrap
    offer(KIND_RATE, '0, '0, 20'hAAAAA);

    // Extreme settings, including a zero window length.
    configure('0, '0, '0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_traffic(30);

    // Widest settings; the long output stall starts with the window fill so
    // the block backs up while items keep coming.
    configure('1, '1, '1);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req  = 1'b1;
    fill_window();

    configure('0, 16'd1, 20'd1000000);
    random_traffic(30);

    random_setup();
    fill_window();

    while (sent_items < ITEM_TARGET) begin
      random_setup();
      random_traffic(40);
    end

    // Drain: all results must arrive, and nothing may follow them.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (owed != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
